### sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg : shared definitions for the first-fit block allocator
// Default sizes, field widths, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // default sizing
  localparam int REGIONS_DEF      = 4;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int BLOCKS_DEF       = 16;

  // fixed field widths
  localparam int THREAD_W   = 2;
  localparam int SIZE_W     = 12;
  localparam int ADDR_W     = 14;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FSCAN,
    S_SPLIT,
    S_RESP
  } state_t;

endpackage

### sv/ffba_region_map.sv
// ----------------------------------------------------------------------------
// ffba_region_map : data address to region decode
// Finds the page region of a free address and its offset inside the page.
// ----------------------------------------------------------------------------
module ffba_region_map
  import ffba_pkg::*;
#(
  parameter int REGIONS    = REGIONS_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int REG_W      = 2
) (
  input  logic [ADDR_W-1:0] addr,
  output logic              hit,
  output logic [REG_W-1:0]  region,
  output logic [ADDR_W-1:0] rel
);

  int idx;
  int a;

  // compare against each page boundary
  always_comb begin
    a   = int'(addr);
    idx = 0;
    for (int r = 1; r < REGIONS; r++) begin
      if (a >= r * PAGE_BYTES) begin
        idx = r;
      end
    end
    hit    = (a < REGIONS * PAGE_BYTES);
    region = REG_W'(idx);
    rel    = ADDR_W'(a - idx * PAGE_BYTES);
  end

endmodule

### sv/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit : first-fit allocator over per-thread pages
// Block table in one synchronous memory, walked one entry per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                              | tuser
//  in_     | in  | thread[1:0] request_size[13:2] release_addr[27:14] | operation
//  out_    | out | data_address[13:0]                              | status
//
//  allocate: walks up to BLOCKS_PER_REGION list entries, plus a split step when
//  a block is split; the memory read port sets the walk pace
//  free: scans the table entries in the address's region
//  one item in flight; the next beat is taken while a result waits in the
//  output register, a stalled result holds the controller in its last state
//  reset is synchronous; the table needs no clearing pass
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int REGIONS           = REGIONS_DEF,
  parameter int PAGE_BYTES        = PAGE_BYTES_DEF,
  parameter int HEADER_BYTES      = HEADER_BYTES_DEF,
  parameter int BLOCKS_PER_REGION = BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // thread, request_size, release_address
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // data_address, zero fill
  output logic [STATUS_W-1:0]   out_tuser   // status
);

  localparam int ENTRIES = REGIONS * BLOCKS_PER_REGION;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LW      = $clog2(BLOCKS_PER_REGION + 1);
  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int REG_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] size;
    logic             free;
    logic [LW-1:0]    next;
  } entry_t;

  function automatic logic [ENTRIES-1:0] head_mask();
    logic [ENTRIES-1:0] m;
    m = '0;
    for (int r = 0; r < REGIONS; r++) begin
      m[r * BLOCKS_PER_REGION] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] ent_idx(input logic [REG_W-1:0] rg,
                                               input int loc);
    return IDX_W'(int'(rg) * BLOCKS_PER_REGION + loc);
  endfunction

  // input fields
  logic [THREAD_W-1:0] in_thread;
  logic [SIZE_W-1:0]   in_size;
  logic [ADDR_W-1:0]   in_addr;
  assign in_thread = in_tdata[THREAD_W-1:0];
  assign in_size   = in_tdata[THREAD_W+SIZE_W-1:THREAD_W];
  assign in_addr   = in_tdata[THREAD_W+SIZE_W+ADDR_W-1:THREAD_W+SIZE_W];

  // registers
  state_t              state_r, state_nxt;
  logic [REG_W-1:0]    reg_r, reg_nxt;
  logic [SIZE_W-1:0]   want_r, want_nxt;
  logic [ADDR_W-1:0]   rel_r, rel_nxt;
  logic [LW-1:0]       cur_r, cur_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic [ENTRIES-1:0]  in_use_r, in_use_nxt;
  logic [REGIONS-1:0]  head_wr_r, head_wr_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_st_r, res_st_nxt;
  entry_t              split_ent_r, split_ent_nxt;
  logic [IDX_W-1:0]    split_idx_r, split_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_st_r, out_st_nxt;

  // block table
  entry_t              mem [ENTRIES];
  entry_t              mem_q;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  entry_t              wr_data;

  // free address decode
  logic                map_hit;
  logic [REG_W-1:0]    map_region;
  logic [ADDR_W-1:0]   map_rel;

  ffba_region_map #(
    .REGIONS    (REGIONS),
    .PAGE_BYTES (PAGE_BYTES),
    .REG_W      (REG_W)
  ) u_map (
    .addr   (in_addr),
    .hit    (map_hit),
    .region (map_region),
    .rel    (map_rel)
  );

  // current entry, untouched heads read as their reset value
  entry_t           ent;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_used;
  always_comb begin
    ent = mem_q;
    if (cur_r == '0 && !head_wr_r[reg_r]) begin
      ent.ofs  = '0;
      ent.size = OFS_W'(PAGE_BYTES - HEADER_BYTES);
      ent.free = 1'b1;
      ent.next = LW'(BLOCKS_PER_REGION);
    end
    cur_idx  = ent_idx(reg_r, int'(cur_r));
    cur_used = in_use_r[cur_idx];
  end

  // lowest spare entry of the region
  logic          sp_found;
  logic [LW-1:0] sp_k;
  always_comb begin
    sp_found = 1'b0;
    sp_k     = '0;
    for (int k = 0; k < BLOCKS_PER_REGION; k++) begin
      if (!sp_found && !in_use_r[ent_idx(reg_r, k)]) begin
        sp_found = 1'b1;
        sp_k     = LW'(k);
      end
    end
  end

  // walk and match terms
  int   left;
  logic fit, do_split, walk_end, free_match, thread_ok, load_out;
  always_comb begin
    left       = int'(ent.size) - int'(want_r);
    fit        = cur_used && ent.free && (int'(ent.size) >= int'(want_r));
    do_split   = (left > HEADER_BYTES) && sp_found;
    walk_end   = (int'(steps_r) + 1 >= BLOCKS_PER_REGION) ||
                 (int'(ent.next) >= BLOCKS_PER_REGION);
    free_match = cur_used && (int'(ent.ofs) + HEADER_BYTES == int'(rel_r));
    thread_ok  = int'(in_thread) < REGIONS;
    load_out   = (state_r == S_RESP) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_ALLOC) begin
            state_nxt = thread_ok ? S_WALK : S_RESP;
          end else begin
            state_nxt = map_hit ? S_FSCAN : S_RESP;
          end
        end
      end
      S_WALK: begin
        if (fit) begin
          state_nxt = do_split ? S_SPLIT : S_RESP;
        end else if (walk_end) begin
          state_nxt = S_RESP;
        end
      end
      S_FSCAN: begin
        if (free_match || int'(cur_r) == BLOCKS_PER_REGION - 1) begin
          state_nxt = S_RESP;
        end
      end
      S_SPLIT: state_nxt = S_RESP;
      S_RESP:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    reg_nxt       = reg_r;
    want_nxt      = want_r;
    rel_nxt       = rel_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    in_use_nxt    = in_use_r;
    head_wr_nxt   = head_wr_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    split_ent_nxt = split_ent_r;
    split_idx_nxt = split_idx_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cur_idx;
    wr_data       = ent;
    in_tready     = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          want_nxt     = in_size;
          rel_nxt      = map_rel;
          cur_nxt      = '0;
          steps_nxt    = '0;
          res_addr_nxt = '0;
          if (in_tuser == OP_ALLOC) begin
            reg_nxt    = REG_W'(int'(in_thread));
            res_st_nxt = ST_NOFIT;
            rd_en      = thread_ok;
            rd_addr    = ent_idx(REG_W'(int'(in_thread)), 0);
          end else begin
            reg_nxt    = map_region;
            res_st_nxt = ST_UNKNOWN;
            rd_en      = map_hit;
            rd_addr    = ent_idx(map_region, 0);
          end
        end
      end
      S_WALK: begin
        if (fit) begin
          // take the block, shrink it when the rest is split off
          wr_en        = 1'b1;
          wr_data.free = 1'b0;
          if (do_split) begin
            wr_data.size = OFS_W'(int'(want_r));
            wr_data.next = sp_k;
          end
          if (cur_r == '0) head_wr_nxt[reg_r] = 1'b1;
          split_idx_nxt      = ent_idx(reg_r, int'(sp_k));
          split_ent_nxt.ofs  = OFS_W'(int'(ent.ofs) + HEADER_BYTES + int'(want_r));
          split_ent_nxt.size = OFS_W'(left - HEADER_BYTES);
          split_ent_nxt.free = 1'b1;
          split_ent_nxt.next = ent.next;
          res_st_nxt   = ST_OK;
          res_addr_nxt = ADDR_W'(int'(reg_r) * PAGE_BYTES + int'(ent.ofs) + HEADER_BYTES);
        end else if (!walk_end) begin
          rd_en     = 1'b1;
          rd_addr   = ent_idx(reg_r, int'(ent.next));
          cur_nxt   = ent.next;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_FSCAN: begin
        if (free_match) begin
          wr_en        = 1'b1;
          wr_data.free = 1'b1;
          if (cur_r == '0) head_wr_nxt[reg_r] = 1'b1;
          res_st_nxt   = ST_OK;
        end else if (int'(cur_r) != BLOCKS_PER_REGION - 1) begin
          rd_en   = 1'b1;
          rd_addr = ent_idx(reg_r, int'(cur_r) + 1);
          cur_nxt = cur_r + 1'b1;
        end
      end
      S_SPLIT: begin
        // link in the new free remainder
        wr_en                   = 1'b1;
        wr_addr                 = split_idx_r;
        wr_data                 = split_ent_r;
        in_use_nxt[split_idx_r] = 1'b1;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = (out_valid_r && !out_tready) || load_out;
    out_addr_nxt  = load_out ? res_addr_r : out_addr_r;
    out_st_nxt    = load_out ? res_st_r : out_st_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_addr_r);
  assign out_tuser  = out_st_r;

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= head_mask();
      head_wr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      head_wr_r   <= head_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    reg_r       <= reg_nxt;
    want_r      <= want_nxt;
    rel_r       <= rel_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    res_addr_r  <= res_addr_nxt;
    res_st_r    <= res_st_nxt;
    split_ent_r <= split_ent_nxt;
    split_idx_r <= split_idx_nxt;
    out_addr_r  <= out_addr_nxt;
    out_st_r    <= out_st_nxt;
  end

endmodule

### sv/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker : port-level checks for the first-fit block allocator
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOFIT ||
                    out_tuser == ST_UNKNOWN))
    else $error("undefined status code");

  // a failed item reports address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("failed item with non-zero address");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb : testbench for first_fit_block_allocator_unit
// Drives allocate and free beats with random gaps and stalls, predicts each
// result with a behavioural copy of the per-thread block tables and checks
// every result beat in order.
// ----------------------------------------------------------------------------
module tb;
  import ffba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG  = REGIONS_DEF;
  localparam int PAGE  = PAGE_BYTES_DEF;
  localparam int HDR   = HEADER_BYTES_DEF;
  localparam int NBLK  = BLOCKS_DEF;
  localparam int NENT  = NREG * NBLK;
  localparam int NIL   = NBLK;
  localparam int N_RAND = 1530;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } alloc_result_t;

  // block table model and queue of expected results
  class alloc_scoreboard;
    int unsigned blk_off [NENT];
    int unsigned blk_size[NENT];
    bit          blk_free[NENT];
    int unsigned blk_next[NENT];
    bit          blk_used[NENT];
    alloc_result_t pending_results[$];
    int errors;

    function void clear_tables();
      for (int i = 0; i < NENT; i++) begin
        blk_off[i]  = 0;
        blk_size[i] = (i % NBLK == 0) ? PAGE - HDR : 0;
        blk_free[i] = 1;
        blk_next[i] = NIL;
        blk_used[i] = (i % NBLK == 0);
      end
      errors = 0;
    endfunction

    function alloc_result_t first_fit(int unsigned reg_i, int unsigned want);
      alloc_result_t r;
      int unsigned base, cur, steps, e, left, k, n;
      r.addr = '0;
      r.status = ST_NOFIT;
      if (reg_i >= NREG) return r;
      base = reg_i * NBLK;
      cur = 0;
      for (steps = 0; steps < NBLK && cur < NBLK; steps++) begin
        e = base + cur;
        if (blk_used[e] && blk_free[e] && blk_size[e] >= want) break;
        cur = blk_next[e];
      end
      if (steps >= NBLK || cur >= NBLK) return r;
      e = base + cur;
      left = blk_size[e] - want;
      k = NIL;
      for (int j = NBLK - 1; j >= 0; j--)
        if (!blk_used[base + j]) k = j;
      // split off the remainder as a new free block
      if (left > HDR && k < NBLK) begin
        n = base + k;
        blk_off[n]  = blk_off[e] + HDR + want;
        blk_size[n] = left - HDR;
        blk_free[n] = 1;
        blk_next[n] = blk_next[e];
        blk_used[n] = 1;
        blk_size[e] = want;
        blk_next[e] = k;
      end
      blk_free[e] = 0;
      r.addr = ADDR_W'(reg_i * PAGE + blk_off[e] + HDR);
      r.status = ST_OK;
      return r;
    endfunction

    function alloc_result_t release_block(int unsigned addr);
      alloc_result_t r;
      int unsigned reg_i, rel, e;
      r.addr = '0;
      r.status = ST_UNKNOWN;
      reg_i = addr / PAGE;
      if (reg_i >= NREG) return r;
      rel = addr - reg_i * PAGE;
      for (int k = 0; k < NBLK; k++) begin
        e = reg_i * NBLK + k;
        if (blk_used[e] && blk_off[e] + HDR == rel) begin
          blk_free[e] = 1;
          r.status = ST_OK;
          return r;
        end
      end
      return r;
    endfunction

    function void note_request(logic op, logic [THREAD_W-1:0] thr,
                               logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
      if (op == OP_ALLOC) pending_results.push_back(first_fit(int'(thr), int'(sz)));
      else pending_results.push_back(release_block(int'(addr)));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [STATUS_W-1:0] s);
      alloc_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: addr %0d status %0d", d, s);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (d[ADDR_W-1:0] !== exp_r.addr) begin
        $error("data_address expected %0d actual %0d", exp_r.addr, d[ADDR_W-1:0]);
        errors++;
      end
      if (d[OUT_DATA_W-1:ADDR_W] !== '0) begin
        $error("zero fill expected 0 actual %0d", d[OUT_DATA_W-1:ADDR_W]);
        errors++;
      end
      if (s !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  alloc_scoreboard sb = new();
  bit calm = 0;       // no idling on either side while set
  bit hold_off = 0;   // receiver long stall request
  bit stim_done = 0;

  first_fit_block_allocator_unit uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // recently handed-out addresses, used to build frees that hit
  logic [ADDR_W-1:0] live_addrs[$];

  task automatic send_beat(logic op, logic [THREAD_W-1:0] thr,
                           logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, addr, sz, thr};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, thr, sz, addr);
  endtask

  task automatic send_alloc(logic [THREAD_W-1:0] thr, logic [SIZE_W-1:0] sz);
    send_beat(OP_ALLOC, thr, sz, ADDR_W'($urandom));
    if (sb.pending_results[$].status == ST_OK)
      live_addrs.push_back(sb.pending_results[$].addr);
  endtask

  task automatic send_free(logic [ADDR_W-1:0] addr);
    send_beat(OP_FREE, THREAD_W'($urandom), SIZE_W'($urandom), addr);
  endtask

  // stimulus
  initial begin
    int pick, idx;
    sb.clear_tables();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, zero size, exact fit, no fit, unknown and double free
    send_alloc(2'd0, 12'd0);
    send_alloc(2'd0, 12'hFFF);
    send_alloc(2'd1, SIZE_W'(PAGE - HDR));
    send_alloc(2'd1, 12'd1);
    send_alloc(2'd2, 12'd100);
    send_alloc(2'd2, 12'd100);
    send_free(ADDR_W'(2 * PAGE + HDR));
    send_free(ADDR_W'(2 * PAGE + HDR));
    send_alloc(2'd2, 12'd50);
    send_free(14'h3FFF);
    send_free(14'd0);
    send_free(ADDR_W'(PAGE + 1));
    send_alloc(2'd3, 12'd4000);
    send_alloc(2'd3, 12'd47);
    send_alloc(2'd3, 12'd25);
    for (int i = 0; i < 8; i++) send_alloc(THREAD_W'(i), 12'h555 ^ SIZE_W'(i * 977));
    send_free(14'h2AAA);
    send_free(14'h1555);
    // random: mostly allocations and frees of live blocks
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 200) calm = 1;
      if (i == 400) calm = 0;
      if (i == 600) hold_off = 1;
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(3) == 0) send_alloc(THREAD_W'($urandom), SIZE_W'($urandom));
        else send_alloc(THREAD_W'($urandom), SIZE_W'($urandom_range(300)));
      end else if (pick < 90 && live_addrs.size() > 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        send_free(live_addrs[idx]);
        live_addrs.delete(idx);
      end else begin
        send_free(ADDR_W'($urandom));
      end
      if (live_addrs.size() > 40) live_addrs.delete(0);
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off && hold_cnt < 300) begin
        hold_cnt++;
        out_tready <= 0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

### sim.f
sv/ffba_pkg.sv
sv/ffba_region_map.sv
sv/first_fit_block_allocator_unit.sv
sv/ffba_checker.sv
tb/tb.sv
